// ----- src/pcs_pkg.sv -----
// Shared constants, payload types and control structs of the stride-2 pointwise convolution.
package pcs_pkg;

  localparam int IN_CH      = 64;
  localparam int OUT_CH     = 32;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  localparam int OC_W = (OUT_CH > 1) ? $clog2(OUT_CH) : 1;
  localparam int IC_W = (IN_CH > 1) ? $clog2(IN_CH) : 1;
  localparam int WA_W = (OUT_CH * IN_CH > 1) ? $clog2(OUT_CH * IN_CH) : 1;

  localparam int CNT_W  = 10;
  localparam int HALF_W = 9;
  localparam int SIZE_W = 11;
  localparam logic [SIZE_W-1:0] COUNT_LIMIT = 11'd1024;
  localparam logic [SIZE_W-1:0] MAP_RESET   = 11'd56;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_ACT    = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]                   command;
    logic [5:0]                   out_index;
    logic [7:0]                   in_index;
    logic signed [DATA_WIDTH-1:0] sample;
    logic                         frame_start;
  } in_t;

  typedef struct packed {
    logic [5:0]                   out_channel;
    logic [8:0]                   out_row;
    logic [8:0]                   out_col;
    logic signed [DATA_WIDTH-1:0] result;
    logic                         last;
  } out_t;

  typedef struct packed {
    logic              take;
    logic [IC_W-1:0]   chan;
    logic [HALF_W-1:0] row_half;
    logic [HALF_W-1:0] col_half;
    logic              calc_issue;
    logic              emit_issue;
    logic [OC_W-1:0]   f;
    logic              last_f;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit_room;
  } dp_sts_t;

endpackage

// ----- src/pcs_ctrl.sv -----
// Controller: request acceptance, pixel and channel counters, map size registers and pass sequencing.
module pcs_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  pcs_pkg::in_t                        in_data,
  output logic                                in_ready,
  input  logic                                cfg_we,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcs_pkg::SIZE_W-1:0]          cfg_data,
  input  pcs_pkg::dp_sts_t                    sts,
  output pcs_pkg::ctl_cmd_t                   cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [pcs_pkg::OC_W-1:0]      f_r, f_nxt;
  logic                          drain_r, drain_nxt;
  logic                          emit_r, emit_nxt;
  logic [pcs_pkg::IC_W-1:0]      chan_r, chan_nxt;
  logic [pcs_pkg::CNT_W-1:0]     row_r, row_nxt;
  logic [pcs_pkg::CNT_W-1:0]     col_r, col_nxt;
  logic [pcs_pkg::SIZE_W-1:0]    width_r, height_r;

  logic                          accept;
  logic [pcs_pkg::IC_W-1:0]      cur_chan;
  logic [pcs_pkg::CNT_W-1:0]     cur_row, cur_col;
  logic                          kept, last_chan, last_f;
  logic [pcs_pkg::SIZE_W-1:0]    row_inc, col_inc, width_lim, height_lim;
  logic                          row_wrap, col_wrap;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cur_chan   = in_data.frame_start ? '0 : chan_r;
    cur_row    = in_data.frame_start ? '0 : row_r;
    cur_col    = in_data.frame_start ? '0 : col_r;
    kept       = !cur_row[0] && !cur_col[0];
    last_chan  = (cur_chan == pcs_pkg::IC_W'(pcs_pkg::IN_CH - 1));
    last_f     = (f_r == pcs_pkg::OC_W'(pcs_pkg::OUT_CH - 1));
    width_lim  = (width_r > pcs_pkg::COUNT_LIMIT) ? pcs_pkg::COUNT_LIMIT : width_r;
    height_lim = (height_r > pcs_pkg::COUNT_LIMIT) ? pcs_pkg::COUNT_LIMIT : height_r;
    col_inc    = {1'b0, cur_col} + 11'd1;
    row_inc    = {1'b0, cur_row} + 11'd1;
    col_wrap   = (col_inc >= width_lim);
    row_wrap   = (row_inc >= height_lim);
  end

  always_comb begin
    state_nxt = state_r;
    f_nxt     = f_r;
    drain_nxt = drain_r;
    emit_nxt  = emit_r;
    chan_nxt  = chan_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cmd       = '0;
    cmd.take     = accept;
    cmd.chan     = cur_chan;
    cmd.row_half = cur_row[pcs_pkg::CNT_W-1:1];
    cmd.col_half = cur_col[pcs_pkg::CNT_W-1:1];
    cmd.f        = f_r;
    cmd.last_f   = last_f;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.command == pcs_pkg::CMD_ACT)) begin
          row_nxt = cur_row;
          col_nxt = cur_col;
          if (last_chan) begin
            chan_nxt = '0;
            col_nxt  = col_wrap ? '0 : col_inc[pcs_pkg::CNT_W-1:0];
            if (col_wrap) begin
              row_nxt = row_wrap ? '0 : row_inc[pcs_pkg::CNT_W-1:0];
            end
          end else begin
            chan_nxt = cur_chan + 1'b1;
          end
          if (kept) begin
            state_nxt = S_CALC;
            f_nxt     = '0;
            emit_nxt  = last_chan;
          end
        end
      end
      S_CALC: begin
        cmd.calc_issue = 1'b1;
        if (last_f) begin
          state_nxt = S_DRAIN;
          drain_nxt = 1'b0;
          f_nxt     = '0;
        end else begin
          f_nxt = f_r + 1'b1;
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = emit_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.emit_room) begin
          cmd.emit_issue = 1'b1;
          if (last_f) begin
            state_nxt = S_IDLE;
            f_nxt     = '0;
          end else begin
            f_nxt = f_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      f_r     <= '0;
      drain_r <= 1'b0;
      emit_r  <= 1'b0;
      chan_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      f_r     <= f_nxt;
      drain_r <= drain_nxt;
      emit_r  <= emit_nxt;
      chan_r  <= chan_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pcs_pkg::MAP_RESET;
      height_r <= pcs_pkg::MAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pcs_pkg::CFG_MAP_WIDTH:  width_r  <= cfg_data;
        pcs_pkg::CFG_MAP_HEIGHT: height_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/pcs_dp.sv -----
// Datapath: weight, bias and accumulator memories, shared multiply-accumulate and result buffer.
module pcs_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  pcs_pkg::in_t        in_data,
  input  pcs_pkg::ctl_cmd_t   cmd,
  output pcs_pkg::dp_sts_t    sts,
  output logic                out_valid,
  input  logic                out_ready,
  output pcs_pkg::out_t       out_data
);

  localparam int DW = pcs_pkg::DATA_WIDTH;

  logic signed [DW-1:0] weight_mem [pcs_pkg::OUT_CH*pcs_pkg::IN_CH];
  logic signed [DW-1:0] bias_mem   [pcs_pkg::OUT_CH];
  logic signed [DW-1:0] acc_mem    [pcs_pkg::OUT_CH];

  logic signed [DW-1:0]          sample_r;
  logic [pcs_pkg::IC_W-1:0]      chan_r;
  logic [pcs_pkg::HALF_W-1:0]    row_r, col_r;

  logic signed [DW-1:0]          w_q, b_q, a_q;
  logic                          s1_valid_r, s2_valid_r, e1_valid_r;
  logic                          s1_first_r;
  logic [pcs_pkg::OC_W-1:0]      s1_f_r, s2_f_r, e1_f_r;
  logic signed [2*DW-1:0]        prod_r;
  logic signed [DW-1:0]          base_r;
  logic                          e1_last_r;
  logic [pcs_pkg::HALF_W-1:0]    e1_row_r, e1_col_r;

  logic                          w_we, b_we, act_take;
  logic [pcs_pkg::WA_W-1:0]      w_waddr, w_raddr;
  logic signed [2*DW-1:0]        prod_sh;
  logic signed [DW-1:0]          acc_sum;

  pcs_pkg::out_t                 fifo_r [2];
  pcs_pkg::out_t                 push_data;
  logic                          wr_ptr_r, rd_ptr_r;
  logic [1:0]                    cnt_r, cnt_nxt;
  logic                          push, pop;
  logic [2:0]                    occ;

  always_comb begin
    w_we = cmd.take && (in_data.command == pcs_pkg::CMD_WEIGHT) &&
           (int'(in_data.out_index) < pcs_pkg::OUT_CH) &&
           (int'(in_data.in_index) < pcs_pkg::IN_CH);
    b_we = cmd.take && (in_data.command == pcs_pkg::CMD_BIAS) &&
           (int'(in_data.out_index) < pcs_pkg::OUT_CH);
    act_take = cmd.take && (in_data.command == pcs_pkg::CMD_ACT);
    w_waddr = pcs_pkg::WA_W'(int'(in_data.out_index[pcs_pkg::OC_W-1:0]) * pcs_pkg::IN_CH +
                             int'(in_data.in_index[pcs_pkg::IC_W-1:0]));
    w_raddr = pcs_pkg::WA_W'(int'(cmd.f) * pcs_pkg::IN_CH + int'(chan_r));
  end

  always_ff @(posedge clk) begin
    if (act_take) begin
      sample_r <= in_data.sample;
      chan_r   <= cmd.chan;
      row_r    <= cmd.row_half;
      col_r    <= cmd.col_half;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_waddr] <= in_data.sample;
    end
    w_q <= weight_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bias_mem[in_data.out_index[pcs_pkg::OC_W-1:0]] <= in_data.sample;
    end
    b_q <= bias_mem[cmd.f];
  end

  assign prod_sh = prod_r >>> pcs_pkg::FRAC_BITS;
  assign acc_sum = base_r + prod_sh[DW-1:0];

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      acc_mem[s2_f_r] <= acc_sum;
    end
    a_q <= acc_mem[cmd.f];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      e1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.calc_issue;
      s2_valid_r <= s1_valid_r;
      e1_valid_r <= cmd.emit_issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_f_r     <= cmd.f;
    s1_first_r <= (chan_r == '0);
    s2_f_r     <= s1_f_r;
    prod_r     <= sample_r * w_q;
    base_r     <= s1_first_r ? b_q : a_q;
    e1_f_r     <= cmd.f;
    e1_last_r  <= cmd.last_f;
    e1_row_r   <= row_r;
    e1_col_r   <= col_r;
  end

  always_comb begin
    push_data             = '0;
    push_data.out_channel = 6'(e1_f_r);
    push_data.out_row     = e1_row_r;
    push_data.out_col     = e1_col_r;
    push_data.result      = a_q;
    push_data.last        = e1_last_r;
    push      = e1_valid_r;
    out_valid = (cnt_r != 2'd0);
    out_data  = fifo_r[rd_ptr_r];
    pop       = out_valid && out_ready;
    occ       = {1'b0, cnt_r} + {2'b00, e1_valid_r};
    sts.emit_room = (occ < (3'd2 + {2'b00, pop}));
    cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/pointwise_conv_stride2.sv -----
// Top level of the stride-2 pointwise convolution: controller, datapath and checks.
// Requests enter on in_valid/in_ready with an in_t payload. A weight or bias load, an
// unused command and an activation of a dropped pixel (odd row or odd column) are each
// accepted without leaving the idle state. An activation of a kept pixel is accepted,
// then runs every output channel through the single shared multiply-accumulate and the
// accumulator memory port, and then waits for that three-stage pipeline to drain.
// After the last input channel of a kept pixel, OUT_CH results follow on
// out_valid/out_ready, one per cycle while the receiver keeps up; last marks the final
// channel. A two-entry result buffer sits between the accumulator read and the output
// port, so a stalled receiver only pauses the readout, and new requests are taken once
// the last result of the pixel is read from the accumulator. Map size registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, and the block itself does not enforce this. Synchronous reset returns
// the map size to 56 by 56, clears the row, column and channel counters and empties the
// result buffer; weights and biases must be loaded again before use.
module pointwise_conv_stride2 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pcs_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pcs_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcs_pkg::SIZE_W-1:0]     cfg_data
);

  pcs_pkg::ctl_cmd_t ctl_cmd;
  pcs_pkg::dp_sts_t  dp_sts;

  pcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (dp_sts),
    .cmd       (ctl_cmd)
  );

  pcs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (ctl_cmd),
    .sts       (dp_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_issue_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl_cmd.calc_issue && ctl_cmd.emit_issue))
    else $error("compute and readout issued in the same cycle");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.emit_issue |-> dp_sts.emit_room)
    else $error("readout issued without room in the result buffer");

  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!ctl_cmd.calc_issue && !ctl_cmd.emit_issue))
    else $error("request accepted while a pass is running");

  a_calc_run: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_cmd.calc_issue && !ctl_cmd.last_f) |=> ctl_cmd.calc_issue)
    else $error("compute pass stopped before the last output channel");
`endif

endmodule

// ----- tb/pointwise_conv_stride2_test.sv -----
// Self-checking testbench for the stride-2 pointwise convolution with a built-in predictor.
module pointwise_conv_stride2_test;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = pcs_pkg::OUT_CH + 16;

  typedef struct {
    pcs_pkg::in_t payload;
    bit           drain_first;
  } pending_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  pcs_pkg::in_t                  in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  pcs_pkg::out_t                 out_data;
  logic                          cfg_we = 1'b0;
  logic [pcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pcs_pkg::SIZE_W-1:0]    cfg_data = '0;

  logic signed [pcs_pkg::DATA_WIDTH-1:0] weight_mem [pcs_pkg::OUT_CH][pcs_pkg::IN_CH];
  logic signed [pcs_pkg::DATA_WIDTH-1:0] bias_mem [pcs_pkg::OUT_CH];
  logic signed [pcs_pkg::DATA_WIDTH-1:0] acc_mem [pcs_pkg::OUT_CH];
  logic [pcs_pkg::SIZE_W-1:0]            map_w = pcs_pkg::MAP_RESET;
  logic [pcs_pkg::SIZE_W-1:0]            map_h = pcs_pkg::MAP_RESET;
  logic [pcs_pkg::CNT_W-1:0]             row_cnt = '0;
  logic [pcs_pkg::CNT_W-1:0]             col_cnt = '0;
  int                                    chan_cnt = 0;

  pending_t      pending_reqs[$];
  pending_t      next_req;
  pcs_pkg::out_t due_results[$];
  int            reqs_queued = 0;
  int            reqs_done = 0;
  int            errors = 0;
  int            cycle_count = 0;
  int            tx_wait = 0;
  int            rx_wait = 0;
  bit            tx_fast = 1'b0;
  bit            rx_fast = 1'b0;

  pointwise_conv_stride2 u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int step_count(input int cur, input int size, output bit wrapped);
    int lim;
    lim = (size > pcs_pkg::COUNT_LIMIT) ? pcs_pkg::COUNT_LIMIT : size;
    wrapped = (cur + 1 >= lim);
    return wrapped ? 0 : cur + 1;
  endfunction

  function automatic void conv_step(input pcs_pkg::in_t req);
    logic signed [2*pcs_pkg::DATA_WIDTH-1:0] prod;
    logic signed [pcs_pkg::DATA_WIDTH-1:0]   base;
    logic                                    kept;
    bit                                      wrapped;
    pcs_pkg::out_t                           res;
    case (req.command)
      pcs_pkg::CMD_WEIGHT: begin
        if (req.out_index < pcs_pkg::OUT_CH && req.in_index < pcs_pkg::IN_CH)
          weight_mem[req.out_index][req.in_index] = req.sample;
      end
      pcs_pkg::CMD_BIAS: begin
        if (req.out_index < pcs_pkg::OUT_CH) bias_mem[req.out_index] = req.sample;
      end
      pcs_pkg::CMD_ACT: begin
        if (req.frame_start) begin
          chan_cnt = 0;
          row_cnt = '0;
          col_cnt = '0;
        end
        kept = !row_cnt[0] && !col_cnt[0];
        if (kept) begin
          for (int f = 0; f < pcs_pkg::OUT_CH; f++) begin
            prod = $signed(req.sample) * $signed(weight_mem[f][chan_cnt]);
            base = (chan_cnt == 0) ? bias_mem[f] : acc_mem[f];
            acc_mem[f] = base + prod[pcs_pkg::FRAC_BITS +: pcs_pkg::DATA_WIDTH];
          end
        end
        if (chan_cnt == pcs_pkg::IN_CH - 1) begin
          if (kept) begin
            for (int f = 0; f < pcs_pkg::OUT_CH; f++) begin
              res.out_channel = 6'(f);
              res.out_row = row_cnt[pcs_pkg::CNT_W-1:1];
              res.out_col = col_cnt[pcs_pkg::CNT_W-1:1];
              res.result = acc_mem[f];
              res.last = (f == pcs_pkg::OUT_CH - 1);
              due_results.push_back(res);
            end
          end
          chan_cnt = 0;
          col_cnt = pcs_pkg::CNT_W'(step_count(col_cnt, map_w, wrapped));
          if (wrapped) row_cnt = pcs_pkg::CNT_W'(step_count(row_cnt, map_h, wrapped));
        end else begin
          chan_cnt++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result(input pcs_pkg::out_t got);
    pcs_pkg::out_t want;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: ch %0d row %0d col %0d result %0d last %0b",
                 got.out_channel, got.out_row, got.out_col, $signed(got.result), got.last);
      return;
    end
    want = due_results.pop_front();
    if (got.out_channel !== want.out_channel || got.out_row !== want.out_row ||
        got.out_col !== want.out_col || got.result !== want.result ||
        got.last !== want.last) begin
      errors++;
      if (errors <= 10) begin
        $write("mismatch: expected ch %0d row %0d col %0d result %0d last %0b, ",
               want.out_channel, want.out_row, want.out_col, $signed(want.result),
               want.last);
        $display("got ch %0d row %0d col %0d result %0d last %0b",
                 got.out_channel, got.out_row, got.out_col, $signed(got.result),
                 got.last);
      end
    end
  endfunction

  function automatic logic [pcs_pkg::DATA_WIDTH-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void queue_req(input int cmd, input int oi, input int ii, input int smp,
                                    input int fs, input bit hold);
    pending_t r;
    r.payload.command = 2'(cmd);
    r.payload.out_index = 6'(oi);
    r.payload.in_index = 8'(ii);
    r.payload.sample = 16'(smp);
    r.payload.frame_start = 1'(fs);
    r.drain_first = hold;
    pending_reqs.push_back(r);
    reqs_queued++;
  endfunction

  function automatic void queue_noise();
    case ($urandom_range(0, 3))
      0: queue_req(pcs_pkg::CMD_WEIGHT, $urandom, $urandom, rand_sample(), $urandom, 1'b0);
      1: queue_req(pcs_pkg::CMD_BIAS, $urandom, $urandom, rand_sample(), $urandom, 1'b0);
      2: queue_req(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, 1'b0);
      default: queue_req(pcs_pkg::CMD_WEIGHT, $urandom_range(0, pcs_pkg::OUT_CH - 1),
                         $urandom_range(0, pcs_pkg::IN_CH - 1), rand_sample(), $urandom,
                         1'b0);
    endcase
  endfunction

  // A pixel is IN_CH activations; noisy pixels carry stray loads and rare restarts.
  function automatic void queue_pixel(input logic fs, input bit noisy, input bit hold_first,
                                      input bit mid_load);
    for (int c = 0; c < pcs_pkg::IN_CH; c++) begin
      if (noisy && $urandom_range(0, 15) == 0) queue_noise();
      if (mid_load && c == pcs_pkg::IN_CH / 2) begin
        queue_req(pcs_pkg::CMD_WEIGHT, 0, pcs_pkg::IN_CH - 1, rand_sample(), 1'b0, 1'b0);
        queue_req(pcs_pkg::CMD_BIAS, 0, 0, rand_sample(), 1'b0, 1'b0);
      end
      queue_req(pcs_pkg::CMD_ACT, $urandom, $urandom, rand_sample(),
                (c == 0) ? fs : (noisy && $urandom_range(0, 199) == 0),
                (c == 0) && hold_first);
    end
  endfunction

  task automatic drain_all();
    while (reqs_done != reqs_queued || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pcs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pcs_pkg::SIZE_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pcs_pkg::CFG_MAP_WIDTH) map_w = value;
    else map_h = value;
  endtask

  task automatic set_map(input logic [pcs_pkg::SIZE_W-1:0] w,
                         input logic [pcs_pkg::SIZE_W-1:0] h);
    drain_all();
    write_reg(pcs_pkg::CFG_MAP_WIDTH, w);
    write_reg(pcs_pkg::CFG_MAP_HEIGHT, h);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        conv_step(in_data);
        reqs_done++;
        tx_wait = tx_fast ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 31) == 0) tx_fast = !tx_fast;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain_first && due_results.size() != 0)) begin
          next_req = pending_reqs.pop_front();
          in_data <= next_req.payload;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        rx_wait = rx_fast ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 31) == 0) rx_fast = !rx_fast;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL pointwise_conv_stride2");
      $finish;
    end
  end

  initial begin
    foreach (acc_mem[f]) acc_mem[f] = '0;

    // Every weight and bias is written before the first activation can read it.
    for (int o = 0; o < pcs_pkg::OUT_CH; o++) begin
      queue_req(pcs_pkg::CMD_BIAS, o, $urandom, rand_sample(), $urandom, 1'b0);
      for (int i = 0; i < pcs_pkg::IN_CH; i++)
        queue_req(pcs_pkg::CMD_WEIGHT, o, i, rand_sample(), $urandom, 1'b0);
    end

    queue_req(pcs_pkg::CMD_BIAS, 0, 8'hff, 16'h7fff, 1'b1, 1'b0);
    queue_req(pcs_pkg::CMD_BIAS, pcs_pkg::OUT_CH - 1, 8'h00, 16'h8000, 1'b0, 1'b0);
    queue_req(pcs_pkg::CMD_WEIGHT, 0, 0, 16'h8000, 1'b0, 1'b0);
    queue_req(pcs_pkg::CMD_WEIGHT, 1, 0, 16'h7fff, 1'b0, 1'b0);
    queue_req(pcs_pkg::CMD_WEIGHT, pcs_pkg::OUT_CH - 1, pcs_pkg::IN_CH - 1, 16'h7fff, 1'b0,
              1'b0);
    queue_req(pcs_pkg::CMD_WEIGHT, 6'h3f, 0, 16'h1234, 1'b0, 1'b0);
    queue_req(pcs_pkg::CMD_WEIGHT, 0, 8'hff, 16'h4321, 1'b0, 1'b0);
    queue_req(pcs_pkg::CMD_WEIGHT, pcs_pkg::OUT_CH, pcs_pkg::IN_CH, 16'h5555, 1'b0, 1'b0);
    queue_req(pcs_pkg::CMD_BIAS, 6'h3f, 0, 16'haaaa, 1'b0, 1'b0);
    queue_req(pcs_pkg::CMD_BIAS, pcs_pkg::OUT_CH, 0, 16'h0f0f, 1'b0, 1'b0);
    queue_req(CMD_UNUSED, 6'h3f, 8'hff, 16'hffff, 1'b1, 1'b0);
    queue_req(CMD_UNUSED, 6'h00, 8'h00, 16'h0000, 1'b0, 1'b0);
    queue_req(pcs_pkg::CMD_ACT, 6'h3f, 8'hff, 16'h8000, 1'b1, 1'b0);
    for (int c = 1; c < pcs_pkg::IN_CH; c++)
      queue_req(pcs_pkg::CMD_ACT, $urandom, $urandom, (c == 1) ? 16'h7fff : rand_sample(),
                1'b0, 1'b0);
    queue_pixel(1'b0, 1'b0, 1'b1, 1'b1);
    queue_pixel(1'b0, 1'b0, 1'b0, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Odd sizes, end of frame and wrap to the first pixel.
    set_map(11'd3, 11'd3);
    queue_pixel(1'b1, 1'b0, 1'b0, 1'b1);
    for (int p = 0; p < 10; p++) queue_pixel(1'b0, 1'b0, 1'b0, 1'b0);

    set_map(11'd1, 11'd2);
    for (int p = 0; p < 4; p++) queue_pixel(p == 0, 1'b0, 1'b0, 1'b0);

    set_map(11'd0, 11'd0);
    for (int p = 0; p < 2; p++) queue_pixel(1'b0, 1'b0, 1'b0, 1'b0);

    set_map(11'd2047, 11'd1024);
    for (int p = 0; p < 3; p++) queue_pixel(p == 0, 1'b0, 1'b0, 1'b0);

    set_map(11'd1024, 11'd2047);
    for (int p = 0; p < 2; p++) queue_pixel(p == 0, 1'b0, 1'b0, 1'b0);

    set_map(11'd2, 11'd5);
    for (int p = 0; p < 12; p++)
      queue_pixel(p == 0 || $urandom_range(0, 3) == 0, 1'b1, $urandom_range(0, 2) == 0,
                  1'b0);

    drain_all();
    if (errors == 0) $display("PASS pointwise_conv_stride2");
    else $display("FAIL pointwise_conv_stride2");
    $finish;
  end

endmodule
